// ===== hw/rtl/cwtt_pkg.sv =====
// shared types and constants of the client wait timeout table
package cwtt_pkg;

  // input item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_WAIT   = 2'd1;
  localparam logic [1:0] KIND_SEND   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // reply codes
  localparam logic CODE_OK      = 1'b0;
  localparam logic CODE_TIMEOUT = 1'b1;

  // timeout register reset value
  localparam logic [7:0] TIMEOUT_RESET = 8'd5;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEND2,
    ST_FLUSH
  } state_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic [1:0]  kind;
    logic        advance;
    logic [15:0] client_id;
    logic [7:0]  timeout;
  } cell_ctrl_t;

  // status gathered from the cell row
  typedef struct packed {
    logic        hit;
    logic [15:0] owner;
    logic        tail;
  } chain_stat_t;

endpackage

// ===== hw/rtl/cwtt_cell.sv =====
// one table slot: busy mark, owner id, countdown and the scan token
module cwtt_cell import cwtt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cell_ctrl_t   ctrl_i,
  input  logic         token_i,
  output logic         token_o,
  output logic         hit_o,
  output logic [15:0]  owner_o
);

  logic        token_q, token_d;
  logic        busy_q, busy_d;
  logic [15:0] owner_q, owner_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        hit_cond;
  logic        act;

  // slot condition that the current operation looks for
  always_comb begin
    case (ctrl_i.kind)
      KIND_TICK: hit_cond = busy_q && (cnt_q == 8'd1);
      KIND_WAIT: hit_cond = !busy_q;
      KIND_SEND: hit_cond = busy_q;
      default:   hit_cond = 1'b0;
    endcase
  end

  assign act     = token_q && ctrl_i.advance;
  assign hit_o   = token_q && hit_cond;
  assign owner_o = hit_o ? owner_q : '0;
  // wait and send stop at the first match, a tick walks the whole row
  assign token_o = token_q && !(hit_cond && (ctrl_i.kind != KIND_TICK));

  // slot update while the token sits here
  always_comb begin
    busy_d  = busy_q;
    owner_d = owner_q;
    cnt_d   = cnt_q;
    token_d = ctrl_i.advance ? token_i : token_q;
    if (act) begin
      case (ctrl_i.kind)
        KIND_WAIT: begin
          if (!busy_q) begin
            busy_d  = 1'b1;
            owner_d = ctrl_i.client_id;
            cnt_d   = ctrl_i.timeout;
          end
        end
        KIND_SEND: begin
          if (busy_q) begin
            busy_d = 1'b0;
          end
        end
        KIND_TICK: begin
          if (busy_q) begin
            cnt_d = cnt_q - 8'd1;
            if (hit_cond) begin
              busy_d = 1'b0;
            end
          end
        end
        default: begin
          busy_d = busy_q;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      token_q <= 1'b0;
      busy_q  <= 1'b0;
    end else begin
      token_q <= token_d;
      busy_q  <= busy_d;
    end
  end

  // slot contents
  always_ff @(posedge clk_i) begin
    owner_q <= owner_d;
    cnt_q   <= cnt_d;
  end

endmodule

// ===== hw/rtl/cwtt_ctrl.sv =====
// sequencer: input transfer, token launch, reply ordering and output register
module cwtt_ctrl import cwtt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [15:0]         client_id_i,
  input  logic signed [31:0]  payload_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         dest_id_o,
  output logic                reply_code_o,
  output logic signed [31:0]  reply_data_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_timeout_ticks_i,
  input  chain_stat_t         stat_i,
  output cell_ctrl_t          ctrl_o,
  output logic                token_start_o
);

  state_e              state_q, state_d;
  logic [1:0]          kind_q;
  logic [15:0]         client_q;
  logic signed [31:0]  payload_q;
  logic [7:0]          timeout_q;
  logic                pend_valid_q, pend_valid_d;
  logic [15:0]         pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  logic [15:0]         dest_q;
  logic                code_q;
  logic signed [31:0]  data_q;
  logic                last_q;
  logic                accept;
  logic                out_free;
  logic                need_push;
  logic                advance;
  logic                push;
  logic [15:0]         push_dest;
  logic                push_code;
  logic signed [31:0]  push_data;
  logic                push_last;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign need_push   = stat_i.hit &&
                       ((kind_q == KIND_SEND) || ((kind_q == KIND_TICK) && pend_valid_q));

  assign ctrl_o.kind      = kind_q;
  assign ctrl_o.advance   = advance;
  assign ctrl_o.client_id = client_q;
  assign ctrl_o.timeout   = timeout_q;

  // next state and reply selection
  always_comb begin
    state_d       = state_q;
    advance       = 1'b0;
    token_start_o = 1'b0;
    pend_d        = pend_q;
    pend_valid_d  = pend_valid_q;
    push          = 1'b0;
    push_dest     = pend_q;
    push_code     = CODE_TIMEOUT;
    push_data     = '0;
    push_last     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        advance = 1'b1;
        if (accept && (kind_i != KIND_UNUSED)) begin
          token_start_o = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        advance = !need_push || out_free;
        if (advance) begin
          if (stat_i.hit) begin
            case (kind_q)
              KIND_WAIT: begin
                state_d = ST_IDLE;
              end
              KIND_SEND: begin
                push      = 1'b1;
                push_dest = stat_i.owner;
                push_code = CODE_OK;
                push_data = payload_q;
                state_d   = ST_SEND2;
              end
              KIND_TICK: begin
                push         = pend_valid_q;
                pend_d       = stat_i.owner;
                pend_valid_d = 1'b1;
                if (stat_i.tail) begin
                  state_d = ST_FLUSH;
                end
              end
              default: begin
                state_d = ST_IDLE;
              end
            endcase
          end else if (stat_i.tail) begin
            state_d = pend_valid_q ? ST_FLUSH : ST_IDLE;
          end
        end
      end
      ST_SEND2: begin
        if (out_free) begin
          push      = 1'b1;
          push_dest = client_q;
          push_code = CODE_OK;
          push_data = payload_q;
          push_last = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push         = 1'b1;
          push_last    = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = push ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);

  // state, pending flag, output valid and timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      timeout_q    <= TIMEOUT_RESET;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_timeout_ticks_i;
      end
    end
  end

  // item fields, pending owner and reply payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= kind_i;
      client_q  <= client_id_i;
      payload_q <= payload_i;
    end
    pend_q <= pend_d;
    if (push) begin
      dest_q <= push_dest;
      code_q <= push_code;
      data_q <= push_data;
      last_q <= push_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dest_id_o    = dest_q;
  assign reply_code_o = code_q;
  assign reply_data_o = data_q;
  assign last_o       = last_q;

`ifndef SYNTHESIS
  a_pend_only_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (kind_q == KIND_TICK))
    else $error("pending reply outside a tick");

  a_send2_only_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEND2) |-> (kind_q == KIND_SEND))
    else $error("second send reply for a non-send item");

  a_hit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.hit |-> (state_q == ST_SCAN))
    else $error("cell hit outside a scan");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> out_free)
    else $error("reply pushed onto a full output register");
`endif

endmodule

// ===== hw/rtl/client_wait_timeout_table.sv =====
// top level: row of slot cells walked by a scan token, plus the sequencer
//
// channel  direction  handshake               payload
// in       input      in_valid_i / in_stall_o kind_i, client_id_i, payload_i
// out      output     out_valid_o/out_stall_i dest_id_o, reply_code_o, reply_data_o, last_o
// cfg      input      cfg_valid_i/cfg_ready_o cfg_timeout_ticks_i
//
// a tick walks the token along the whole row, a wait or send stops it at the first
// matching slot, and a send or a tick with a timeout adds a trailing reply after the scan
// the token moves one cell per cycle; it holds in place while a reply waits on out_stall_i
// reset empties the table and loads the timeout register with 5
// in_stall_o is high from the accepting edge until the item is done, last reply included
module client_wait_timeout_table import cwtt_pkg::*; #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          kind_i,
  input  logic [15:0]         client_id_i,
  input  logic signed [31:0]  payload_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         dest_id_o,
  output logic                reply_code_o,
  output logic signed [31:0]  reply_data_o,
  output logic                last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_timeout_ticks_i
);

  cell_ctrl_t              ctrl;
  chain_stat_t             stat;
  logic                    token_start;
  logic [TABLE_SLOTS:0]    token_chain;
  logic [TABLE_SLOTS-1:0]  hit_vec;
  logic [15:0]             owner_vec [TABLE_SLOTS];

  assign token_chain[0] = token_start;

  // row of slot cells, the token hands from each cell to the next
  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    cwtt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .token_i (token_chain[i]),
      .token_o (token_chain[i+1]),
      .hit_o   (hit_vec[i]),
      .owner_o (owner_vec[i])
    );
  end

  // gather the single matching slot
  always_comb begin
    stat.hit   = |hit_vec;
    stat.tail  = token_chain[TABLE_SLOTS];
    stat.owner = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      stat.owner = stat.owner | owner_vec[i];
    end
  end

  cwtt_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .kind_i              (kind_i),
    .client_id_i         (client_id_i),
    .payload_i           (payload_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .dest_id_o           (dest_id_o),
    .reply_code_o        (reply_code_o),
    .reply_data_o        (reply_data_o),
    .last_o              (last_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_timeout_ticks_i (cfg_timeout_ticks_i),
    .stat_i              (stat),
    .ctrl_o              (ctrl),
    .token_start_o       (token_start)
  );

`ifndef SYNTHESIS
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec))
    else $error("more than one cell matched at once");

  a_no_token_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !stat.hit)
    else $error("cell matched while the sequencer is idle");

  a_tail_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.tail && ctrl.advance) |=> !stat.hit)
    else $error("cell matched after the token left the row");
`endif

endmodule
